/* sv/yuv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// YUV to RGB pixel pair package
// Shared word types, matrix coefficients and the channel clamp for the
// pixel pair colour converter.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

  // Width of every intermediate sum. The largest magnitude is about 137000.
  localparam int unsigned SumW = 20;
  localparam int unsigned PixW = 8;

  // Matrix choices of the mode register.
  typedef enum logic {
    MATRIX_FULL   = 1'b0,
    MATRIX_STUDIO = 1'b1
  } matrix_e;

  localparam matrix_e MatrixReset = MATRIX_STUDIO;

  // Full range coefficients.
  localparam logic signed [SumW-1:0] FullKy  = SumW'(256);
  localparam logic signed [SumW-1:0] FullKrv = SumW'(403);
  localparam logic signed [SumW-1:0] FullKgu = SumW'(48);
  localparam logic signed [SumW-1:0] FullKgv = SumW'(120);
  localparam logic signed [SumW-1:0] FullKbu = SumW'(475);

  // Studio range BT.601 coefficients.
  localparam logic signed [SumW-1:0] StudioKy  = SumW'(298);
  localparam logic signed [SumW-1:0] StudioKrv = SumW'(409);
  localparam logic signed [SumW-1:0] StudioKgu = SumW'(100);
  localparam logic signed [SumW-1:0] StudioKgv = SumW'(208);
  localparam logic signed [SumW-1:0] StudioKbu = SumW'(516);

  localparam logic signed [9:0] LumaOffset   = 10'sd16;
  localparam logic signed [9:0] ChromaOffset = 10'sd128;
  localparam logic [PixW-1:0]   AlphaValue   = 8'hFF;

  // Input word: two luma samples sharing one chroma pair.
  typedef struct packed {
    logic [PixW-1:0] luma_first;
    logic [PixW-1:0] luma_second;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] chroma_red;
  } yuv_pair_t;

  // Output word: two RGB pixels and a common alpha.
  typedef struct packed {
    logic [PixW-1:0] red_first;
    logic [PixW-1:0] green_first;
    logic [PixW-1:0] blue_first;
    logic [PixW-1:0] red_second;
    logic [PixW-1:0] green_second;
    logic [PixW-1:0] blue_second;
    logic [PixW-1:0] alpha;
  } rgb_pair_t;

  // Chroma contributions shared by both pixels of a pair.
  typedef struct packed {
    logic signed [SumW-1:0] red_term;
    logic signed [SumW-1:0] green_term;
    logic signed [SumW-1:0] blue_term;
  } chroma_terms_t;

  // One converted pixel.
  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_rgb_t;

  // Floor shift by eight and clamp to 0..255.
  function automatic logic [PixW-1:0] clamp_channel(logic signed [SumW-1:0] sum);
    logic [PixW-1:0] res;
    if (sum[SumW-1]) begin
      res = '0;
    end else if (|sum[SumW-2:16]) begin
      res = '1;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

endpackage

/* sv/yuv2rgb_ifs.sv */
// ----------------------------------------------------------------------------
// YUV to RGB stream interfaces
// Valid/ready channels carrying the input and output words of the converter.
// ----------------------------------------------------------------------------
interface yuv2rgb_in_if import yuv2rgb_pkg::*; ();
  logic      valid;
  logic      ready;
  yuv_pair_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface yuv2rgb_out_if import yuv2rgb_pkg::*; ();
  logic      valid;
  logic      ready;
  rgb_pair_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/yuv2rgb_chroma.sv */
// ----------------------------------------------------------------------------
// YUV to RGB chroma terms
// Removes the chroma offset and forms the U and V products that both pixels
// of a pair add to their luma term.
// ----------------------------------------------------------------------------
module yuv2rgb_chroma import yuv2rgb_pkg::*; (
  input  matrix_e         matrix_i,
  input  logic [PixW-1:0] chroma_blue_i,
  input  logic [PixW-1:0] chroma_red_i,
  output chroma_terms_t   terms_o
);

  logic signed [9:0]      u_s;
  logic signed [9:0]      v_s;
  logic signed [SumW-1:0] u_w;
  logic signed [SumW-1:0] v_w;
  logic signed [SumW-1:0] krv;
  logic signed [SumW-1:0] kgu;
  logic signed [SumW-1:0] kgv;
  logic signed [SumW-1:0] kbu;

  // Centre the chroma samples around zero.
  assign u_s = $signed({2'b00, chroma_blue_i}) - ChromaOffset;
  assign v_s = $signed({2'b00, chroma_red_i}) - ChromaOffset;
  assign u_w = SumW'(u_s);
  assign v_w = SumW'(v_s);

  // Coefficient selection by matrix.
  always_comb begin
    unique case (matrix_i)
      MATRIX_FULL: begin
        krv = FullKrv;
        kgu = FullKgu;
        kgv = FullKgv;
        kbu = FullKbu;
      end
      default: begin
        krv = StudioKrv;
        kgu = StudioKgu;
        kgv = StudioKgv;
        kbu = StudioKbu;
      end
    endcase
  end

  // Constant products; green carries both chroma terms, already negated.
  assign terms_o.red_term   = v_w * krv;
  assign terms_o.green_term = -(u_w * kgu) - (v_w * kgv);
  assign terms_o.blue_term  = u_w * kbu;

endmodule

/* sv/yuv2rgb_pixel.sv */
// ----------------------------------------------------------------------------
// YUV to RGB pixel
// Scales one luma sample, adds the shared chroma terms and clamps each
// channel to eight bits.
// ----------------------------------------------------------------------------
module yuv2rgb_pixel import yuv2rgb_pkg::*; (
  input  matrix_e         matrix_i,
  input  logic [PixW-1:0] luma_i,
  input  chroma_terms_t   terms_i,
  output pixel_rgb_t      pixel_o
);

  logic signed [9:0]      y_s;
  logic signed [SumW-1:0] ky;
  logic signed [SumW-1:0] luma_term;

  // Studio range removes the luma offset, which may leave a negative value.
  always_comb begin
    unique case (matrix_i)
      MATRIX_FULL: begin
        y_s = $signed({2'b00, luma_i});
        ky  = FullKy;
      end
      default: begin
        y_s = $signed({2'b00, luma_i}) - LumaOffset;
        ky  = StudioKy;
      end
    endcase
  end

  assign luma_term = SumW'(y_s) * ky;

  // Sum and clamp each channel.
  assign pixel_o.red   = clamp_channel(luma_term + terms_i.red_term);
  assign pixel_o.green = clamp_channel(luma_term + terms_i.green_term);
  assign pixel_o.blue  = clamp_channel(luma_term + terms_i.blue_term);

endmodule

/* sv/yuv_to_rgb_pixel_pair_core.sv */
// ----------------------------------------------------------------------------
// YUV to RGB pixel pair converter
// Converts two adjacent luma samples with one shared chroma pair into two
// RGB pixels with constant alpha.
// ----------------------------------------------------------------------------
// A pair is captured in an input register and converted in one pass of
// constant multiplies, adds and clamps into an output register. Each word
// passes through the input register and then the output register, and the
// block takes one pair every clock while the output is not stalled. Ready on
// the input falls only when both registers hold words and the output is
// stalled. The matrix register (reset: studio range) is written through
// cfg_we_i and should change only while no word is in flight.
module yuv_to_rgb_pixel_pair_core import yuv2rgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  yuv2rgb_in_if.sink         in_i,
  yuv2rgb_out_if.source      out_o
);

  matrix_e       matrix_q;
  logic          in_valid_q;
  yuv_pair_t     in_data_q;
  logic          out_valid_q;
  rgb_pair_t     out_data_q;
  rgb_pair_t     out_data_d;
  logic          out_en;
  logic          in_en;
  chroma_terms_t terms;
  pixel_rgb_t    pix_first;
  pixel_rgb_t    pix_second;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= MatrixReset;
    end else if (cfg_we_i) begin
      matrix_q <= matrix_e'(cfg_wdata_i);
    end
  end

  // Each register advances when the one after it is free or being emptied.
  assign out_en     = !out_valid_q || out_o.ready;
  assign in_en      = !in_valid_q || out_en;
  assign in_i.ready = in_en;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_en) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_i.valid) begin
      in_data_q <= in_i.data;
    end
  end

  // Conversion datapath.
  yuv2rgb_chroma u_chroma (
    .matrix_i      (matrix_q),
    .chroma_blue_i (in_data_q.chroma_blue),
    .chroma_red_i  (in_data_q.chroma_red),
    .terms_o       (terms)
  );

  yuv2rgb_pixel u_pixel_first (
    .matrix_i (matrix_q),
    .luma_i   (in_data_q.luma_first),
    .terms_i  (terms),
    .pixel_o  (pix_first)
  );

  yuv2rgb_pixel u_pixel_second (
    .matrix_i (matrix_q),
    .luma_i   (in_data_q.luma_second),
    .terms_i  (terms),
    .pixel_o  (pix_second)
  );

  always_comb begin
    out_data_d.red_first    = pix_first.red;
    out_data_d.green_first  = pix_first.green;
    out_data_d.blue_first   = pix_first.blue;
    out_data_d.red_second   = pix_second.red;
    out_data_d.green_second = pix_second.green;
    out_data_d.blue_second  = pix_second.blue;
    out_data_d.alpha        = AlphaValue;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

/* bench/rgb_pair_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel pair scoreboard
// Predicts the RGB pair for each accepted YUV word under the current matrix
// and compares every output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
package rgb_pair_scoreboard_pkg;
  import yuv2rgb_pkg::*;

  class rgb_pair_scoreboard;
    matrix_e     matrix;
    rgb_pair_t   expected_q[$];
    int unsigned accepted;
    int unsigned checked;
    int unsigned errors;

    function new();
      matrix   = MatrixReset;
      accepted = 0;
      checked  = 0;
      errors   = 0;
    endfunction

    // Floor shift by eight, then saturate to the 8-bit pixel range.
    function logic [PixW-1:0] saturate_channel(int sum);
      if (sum < 0) begin
        return '0;
      end
      if ((sum >>> 8) > 255) begin
        return '1;
      end
      return PixW'(sum >>> 8);
    endfunction

    // One pixel from its luma and the shared, centred chroma pair.
    function pixel_rgb_t pixel_from_luma(logic [PixW-1:0] luma, int u, int v);
      int         y;
      int         ky;
      int         krv;
      int         kgu;
      int         kgv;
      int         kbu;
      pixel_rgb_t px;
      if (matrix == MATRIX_STUDIO) begin
        y   = int'(luma) - int'(LumaOffset);
        ky  = 298;
        krv = 409;
        kgu = 100;
        kgv = 208;
        kbu = 516;
      end else begin
        y   = int'(luma);
        ky  = 256;
        krv = 403;
        kgu = 48;
        kgv = 120;
        kbu = 475;
      end
      px.red   = saturate_channel(ky * y + krv * v);
      px.green = saturate_channel(ky * y - kgu * u - kgv * v);
      px.blue  = saturate_channel(ky * y + kbu * u);
      return px;
    endfunction

    // An input word was accepted: predict the output word it will produce.
    function void note_input(yuv_pair_t word);
      int         u;
      int         v;
      pixel_rgb_t left;
      pixel_rgb_t right;
      rgb_pair_t  pair;
      u     = int'(word.chroma_blue) - int'(ChromaOffset);
      v     = int'(word.chroma_red) - int'(ChromaOffset);
      left  = pixel_from_luma(word.luma_first, u, v);
      right = pixel_from_luma(word.luma_second, u, v);
      pair.red_first    = left.red;
      pair.green_first  = left.green;
      pair.blue_first   = left.blue;
      pair.red_second   = right.red;
      pair.green_second = right.green;
      pair.blue_second  = right.blue;
      pair.alpha        = AlphaValue;
      expected_q.push_back(pair);
      accepted++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void check_field(string name, logic [PixW-1:0] want, logic [PixW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // An output word was accepted: compare it with the oldest prediction.
    function void check_result(rgb_pair_t got);
      rgb_pair_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: output word %h arrived with nothing expected, expected none, actual %h",
                 $time, got, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      check_field("red_first",    want.red_first,    got.red_first);
      check_field("green_first",  want.green_first,  got.green_first);
      check_field("blue_first",   want.blue_first,   got.blue_first);
      check_field("red_second",   want.red_second,   got.red_second);
      check_field("green_second", want.green_second, got.green_second);
      check_field("blue_second",  want.blue_second,  got.blue_second);
      check_field("alpha",        want.alpha,        got.alpha);
    endfunction
  endclass

endpackage

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel pair converter testbench
// Drives directed corner pairs and then random pairs through the converter
// under both matrices and several patterns of sender gaps and receiver
// stalls, checking every output word against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb;
  import yuv2rgb_pkg::*;
  import rgb_pair_scoreboard_pkg::*;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 80;
  localparam int unsigned DirectedItems = 13;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned matrix_writes;

  rgb_pair_scoreboard sb;

  yuv2rgb_in_if  in_if ();
  yuv2rgb_out_if out_if ();

  yuv_to_rgb_pixel_pair_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Clock with a 2 ns period.
  always #1 clk_i = ~clk_i;

  // Receiver: stall the output at random according to the current phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor both handshakes with the values sampled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.data);
      end
    end
  end

  // Present one input word after a random gap and hold it until accepted.
  task automatic send_pair(yuv_pair_t word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.data  <= yuv_pair_t'($urandom);
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= word;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
  endtask

  // Stop sending and wait until every predicted word has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write the matrix register while no word is in flight.
  task automatic write_matrix(matrix_e m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.matrix = m;
    matrix_writes++;
  endtask

  // Sample value biased towards the interesting points of the range.
  function automatic logic [PixW-1:0] pick_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0:       return 8'd0;
        1:       return 8'd255;
        2:       return 8'd16;
        3:       return 8'd235;
        default: return 8'd128;
      endcase
    end
    return PixW'($urandom_range(255));
  endfunction

  function automatic yuv_pair_t random_pair();
    yuv_pair_t word;
    word.luma_first  = pick_sample();
    word.luma_second = pick_sample();
    word.chroma_blue = pick_sample();
    word.chroma_red  = pick_sample();
    return word;
  endfunction

  // Main sequence: reset, directed pairs, random phases, drain and verdict.
  initial begin
    yuv_pair_t   corners[DirectedItems];
    int unsigned sender_pcts[4];
    int unsigned stall_pcts[4];
    sb = new();
    sender_pcts = '{0, 86, 0, 36};
    stall_pcts  = '{0, 0, 86, 36};
    // Black, white, studio black and white levels, chroma extremes in every
    // combination, luma below the studio offset and alternating bit patterns.
    corners = '{
      '{8'd0,   8'd0,   8'd128, 8'd128},
      '{8'd255, 8'd255, 8'd128, 8'd128},
      '{8'd16,  8'd235, 8'd128, 8'd128},
      '{8'd0,   8'd255, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd255, 8'd0},
      '{8'd15,  8'd1,   8'd128, 8'd128},
      '{8'd128, 8'd128, 8'd0,   8'd128},
      '{8'd128, 8'd128, 8'd255, 8'd128},
      '{8'd128, 8'd128, 8'd128, 8'd0},
      '{8'd128, 8'd128, 8'd128, 8'd255},
      '{8'hAA,  8'h55,  8'hAA,  8'h55}
    };
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    matrix_writes      = 0;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners first under the reset matrix, then under full range.
    foreach (corners[i]) begin
      send_pair(corners[i]);
    end
    write_matrix(MATRIX_FULL);
    foreach (corners[i]) begin
      send_pair(corners[i]);
    end
    write_matrix(MATRIX_STUDIO);

    // Random phases with varying idling and a matrix chosen per phase.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_matrix((p[0] ^ p[2]) ? MATRIX_STUDIO : MATRIX_FULL);
      sender_idle_pct    = sender_pcts[p % 4];
      receiver_stall_pct = stall_pcts[p % 4];
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // Midway through phase 3 the sender holds off until the pipeline has emptied.
        if (n == PhaseItems / 2 && p == 3) begin
          wait_drained();
        end
        send_pair(random_pair());
      end
    end

    // Let the last words out and give the block time for any stray word.
    wait_drained();
    receiver_stall_pct = 0;
    repeat (4) @(posedge clk_i);

    $display("Checked %0d of %0d pixel pairs across %0d matrix writes,", sb.checked,
             sb.accepted, matrix_writes);
    $display("with free-running, gapped, stalled and mixed handshake phases.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
